// File: design/rssu_pkg.sv
`default_nettype none
package rssu_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MAC,
        S_OUT
    } t_state;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_FILTER_ENABLE    = 3'd0,
        CFG_COEF_FEEDBACK    = 3'd1,
        CFG_COEF_INPUT       = 3'd2,
        CFG_COEF_PREV_INPUT  = 3'd3,
        CFG_SAMPLES_PER_REV  = 3'd4,
        CFG_FLASH_TICKS      = 3'd5,
        CFG_INITIAL_INTERVAL = 3'd6
    } t_cfg_idx;

    localparam logic        RST_FILTER_ENABLE    = 1'b1;
    localparam logic [15:0] RST_COEF_FEEDBACK    = 16'd64515;
    localparam logic [15:0] RST_COEF_INPUT       = 16'd511;
    localparam logic [15:0] RST_COEF_PREV_INPUT  = 16'd511;
    localparam logic [10:0] RST_SAMPLES_PER_REV  = 11'd256;
    localparam logic [23:0] RST_FLASH_TICKS      = 24'd1000;
    localparam logic [31:0] RST_INITIAL_INTERVAL = 32'd10000;
    localparam logic [31:0] ALL_ONES             = 32'hFFFF_FFFF;

    localparam int DIV_STEPS = 32;
    localparam int MAC_STEPS = 4;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mac_step;
    } t_cmd;

    typedef struct packed {
        logic edge_in;
        logic mac_need;
        logic div_last;
        logic mac_last;
    } t_stat;

endpackage
`default_nettype wire

// File: design/rssu_ctrl.sv
`default_nettype none
module rssu_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_out_stall,
    input  rssu_pkg::t_stat  i_stat,
    output rssu_pkg::t_cmd   o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);
    import rssu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.mac_step = 1'b0;
        o_in_stall     = 1'b1;
        o_out_valid    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.edge_in) begin
                        n_state = S_DIV;
                    end else if (i_stat.mac_need) begin
                        n_state = S_MAC;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_stat.mac_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: design/rssu_dp.sv
`default_nettype none
module rssu_dp #(
    parameter int BANK_DEPTH = 1024
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  rssu_pkg::t_cmd   i_cmd,
    output rssu_pkg::t_stat  o_stat,
    input  wire              i_cfg_we,
    input  wire  [2:0]       i_cfg_index,
    input  wire  [31:0]      i_cfg_data,
    input  wire              i_tach_edge,
    input  wire  [15:0]      i_adc_value,
    output logic             o_strobe_on,
    output logic             o_overrun,
    output logic             o_sample_valid,
    output logic             o_sample_bank,
    output logic [9:0]       o_sample_index,
    output logic [15:0]      o_sample_value,
    output logic             o_revolution_done,
    output logic [31:0]      o_period_ticks,
    output logic             o_finished_bank,
    output logic [10:0]      o_finished_count,
    output logic [7:0]       o_revolution_count
);
    import rssu_pkg::*;

    localparam int WIW = $clog2(BANK_DEPTH + 1);
    localparam logic [WIW-1:0] DEPTH_W = WIW'(BANK_DEPTH);

    // configuration
    logic        r_filter_en;
    logic [15:0] r_coef_fb, r_coef_in, r_coef_prev;
    logic [10:0] r_spr;
    logic [23:0] r_flash;

    // tick state
    logic [31:0]    r_tick, r_interval, r_match, r_strobe_match, r_strobe_off;
    logic           r_armed, r_level, r_bank, r_overrun;
    logic [WIW-1:0] r_widx;
    logic [15:0]    r_prev_f, r_prev_raw;
    logic [7:0]     r_rev;

    // divider
    logic [4:0]  r_div_cnt;
    logic [10:0] r_rem, r_divisor;
    logic [31:0] r_quo;

    // filter
    logic [1:0]  r_mac_cnt;
    logic [15:0] r_x;
    logic [31:0] r_prod;
    logic [33:0] r_acc;

    logic [31:0] t_next, flash1;
    logic [32:0] match_sum;
    logic        hit;
    logic [11:0] rem_sh;
    logic        q_bit;
    logic [31:0] q_full;
    logic [15:0] mul_a, mul_b;
    logic [33:0] acc_fin;
    logic [15:0] y_sat;

    assign t_next    = r_tick + 32'd1;
    assign flash1    = (r_flash == 24'd0) ? 32'd1 : {8'd0, r_flash};
    assign hit       = r_armed && (t_next == r_match);
    assign match_sum = {1'b0, r_match} + {1'b0, r_interval};

    assign rem_sh = {r_rem, r_quo[31]};
    assign q_bit  = (rem_sh >= {1'b0, r_divisor});
    assign q_full = {r_quo[30:0], q_bit};

    always_comb begin
        case (r_mac_cnt)
            2'd0:    begin mul_a = r_coef_fb;   mul_b = r_prev_f;   end
            2'd1:    begin mul_a = r_coef_in;   mul_b = r_x;        end
            2'd2:    begin mul_a = r_coef_prev; mul_b = r_prev_raw; end
            default: begin mul_a = 16'd0;       mul_b = 16'd0;      end
        endcase
    end

    assign acc_fin = r_acc + {2'd0, r_prod};
    assign y_sat   = (acc_fin[33:32] != 2'd0) ? 16'hFFFF : acc_fin[31:16];

    assign o_stat.edge_in  = i_tach_edge;
    assign o_stat.mac_need = !i_tach_edge && hit && (r_widx < DEPTH_W) && r_filter_en;
    assign o_stat.div_last = (r_div_cnt == 5'(DIV_STEPS - 1));
    assign o_stat.mac_last = (r_mac_cnt == 2'(MAC_STEPS - 1));

    assign o_strobe_on        = r_level;
    assign o_overrun          = r_overrun;
    assign o_revolution_count = r_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en    <= RST_FILTER_ENABLE;
            r_coef_fb      <= RST_COEF_FEEDBACK;
            r_coef_in      <= RST_COEF_INPUT;
            r_coef_prev    <= RST_COEF_PREV_INPUT;
            r_spr          <= RST_SAMPLES_PER_REV;
            r_flash        <= RST_FLASH_TICKS;
            r_tick         <= 32'd0;
            r_interval     <= RST_INITIAL_INTERVAL;
            r_match        <= RST_INITIAL_INTERVAL;
            r_armed        <= 1'b1;
            r_strobe_match <= ALL_ONES;
            r_strobe_off   <= ALL_ONES;
            r_level        <= 1'b0;
            r_bank         <= 1'b0;
            r_widx         <= '0;
            r_prev_f       <= 16'd0;
            r_prev_raw     <= 16'd0;
            r_rev          <= 8'd0;
            r_overrun      <= 1'b0;
            r_div_cnt      <= 5'd0;
            r_mac_cnt      <= 2'd0;
            o_sample_valid    <= 1'b0;
            o_sample_bank     <= 1'b0;
            o_sample_index    <= 10'd0;
            o_sample_value    <= 16'd0;
            o_revolution_done <= 1'b0;
            o_period_ticks    <= 32'd0;
            o_finished_bank   <= 1'b0;
            o_finished_count  <= 11'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FILTER_ENABLE:   r_filter_en <= i_cfg_data[0];
                    CFG_COEF_FEEDBACK:   r_coef_fb   <= i_cfg_data[15:0];
                    CFG_COEF_INPUT:      r_coef_in   <= i_cfg_data[15:0];
                    CFG_COEF_PREV_INPUT: r_coef_prev <= i_cfg_data[15:0];
                    CFG_SAMPLES_PER_REV: r_spr       <= i_cfg_data[10:0];
                    CFG_FLASH_TICKS:     r_flash     <= i_cfg_data[23:0];
                    CFG_INITIAL_INTERVAL: begin
                        r_interval <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                        r_match    <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                        r_armed    <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                o_sample_valid    <= 1'b0;
                o_sample_bank     <= 1'b0;
                o_sample_index    <= 10'd0;
                o_sample_value    <= 16'd0;
                o_revolution_done <= 1'b0;
                o_period_ticks    <= 32'd0;
                o_finished_bank   <= 1'b0;
                o_finished_count  <= 11'd0;
                if (i_tach_edge) begin
                    o_revolution_done <= 1'b1;
                    o_period_ticks    <= r_tick;
                    o_finished_bank   <= r_bank;
                    o_finished_count  <= 11'(r_widx);
                    r_tick         <= 32'd0;
                    r_bank         <= ~r_bank;
                    r_widx         <= '0;
                    r_strobe_match <= {1'b0, r_tick[31:1]};
                    r_level        <= 1'b1;
                    r_strobe_off   <= flash1;
                    r_armed        <= 1'b1;
                    r_rev          <= r_rev + 8'd1;
                    // period divide runs one quotient bit per cycle
                    r_quo          <= r_tick;
                    r_rem          <= 11'd0;
                    r_divisor      <= (r_spr == 11'd0) ? 11'd1 : r_spr;
                    r_div_cnt      <= 5'd0;
                end else begin
                    r_tick <= t_next;
                    if (t_next == r_strobe_match) begin
                        r_level      <= 1'b1;
                        r_strobe_off <= t_next + flash1;
                    end else if (t_next == r_strobe_off) begin
                        r_level <= 1'b0;
                    end
                    if (hit) begin
                        if (r_widx >= DEPTH_W) begin
                            r_overrun <= 1'b1;
                        end else begin
                            r_overrun      <= 1'b0;
                            o_sample_valid <= 1'b1;
                            o_sample_bank  <= r_bank;
                            o_sample_index <= 10'(r_widx);
                            o_sample_value <= i_adc_value;
                            r_widx         <= r_widx + WIW'(1);
                            r_x            <= i_adc_value;
                            r_acc          <= 34'd0;
                            r_mac_cnt      <= 2'd0;
                        end
                        if (match_sum < {1'b0, ALL_ONES}) begin
                            r_match <= match_sum[31:0];
                        end else begin
                            r_armed <= 1'b0;
                        end
                    end
                end
            end

            if (i_cmd.div_step) begin
                r_rem     <= q_bit ? 11'(rem_sh - {1'b0, r_divisor}) : rem_sh[10:0];
                r_quo     <= q_full;
                r_div_cnt <= r_div_cnt + 5'd1;
                if (o_stat.div_last) begin
                    r_interval <= (q_full == 32'd0) ? 32'd1 : q_full;
                    r_match    <= (q_full == 32'd0) ? 32'd1 : q_full;
                end
            end

            if (i_cmd.mac_step) begin
                r_prod    <= mul_a * mul_b;
                r_mac_cnt <= r_mac_cnt + 2'd1;
                if (r_mac_cnt != 2'd0) begin
                    r_acc <= acc_fin;
                end
                if (o_stat.mac_last) begin
                    o_sample_value <= y_sat;
                    r_prev_f       <= y_sat;
                    r_prev_raw     <= r_x;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: design/rotor_synchronous_sampler_strobe_unit.sv
`default_nettype none
// rotor-synchronous sampler and strobe
// input channel: one word per timer tick (tach edge flag and adc value),
// handshake i_in_valid / o_in_stall. output channel: one word per tick,
// handshake o_out_valid / i_out_stall, fields on their own ports.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 filter enable .. 6 initial interval); write only while idle.
// an ordinary tick has its result valid the cycle after accept; a sample
// through the filter first takes the one shared 16x16 multiplier, used for
// three products over four steps; a tach edge first takes the restoring
// divider that turns the period into a sample interval one bit per cycle.
// one word is in flight at a time: the input stalls until the result is
// taken, and a stalled result holds all its fields.
// reset (synchronous, active low) loads the register defaults, clears the
// tick counter, banks and filter history, and leaves both channels empty.
module rotor_synchronous_sampler_strobe_unit #(
    parameter int BANK_DEPTH = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_tach_edge,
    input  wire  [15:0] i_adc_value,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_strobe_on,
    output logic        o_overrun,
    output logic        o_sample_valid,
    output logic        o_sample_bank,
    output logic [9:0]  o_sample_index,
    output logic [15:0] o_sample_value,
    output logic        o_revolution_done,
    output logic [31:0] o_period_ticks,
    output logic        o_finished_bank,
    output logic [10:0] o_finished_count,
    output logic [7:0]  o_revolution_count,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import rssu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rssu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rssu_dp #(.BANK_DEPTH(BANK_DEPTH)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_tach_edge        (i_tach_edge),
        .i_adc_value        (i_adc_value),
        .o_strobe_on        (o_strobe_on),
        .o_overrun          (o_overrun),
        .o_sample_valid     (o_sample_valid),
        .o_sample_bank      (o_sample_bank),
        .o_sample_index     (o_sample_index),
        .o_sample_value     (o_sample_value),
        .o_revolution_done  (o_revolution_done),
        .o_period_ticks     (o_period_ticks),
        .o_finished_bank    (o_finished_bank),
        .o_finished_count   (o_finished_count),
        .o_revolution_count (o_revolution_count)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_edge_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_revolution_done) |-> !o_sample_valid)
        else $error("sample emitted on a tach edge");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_revolution_done) |->
            (o_period_ticks == 32'd0 && o_finished_count == 11'd0))
        else $error("revolution fields set without a tach edge");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

import rssu_pkg::*;

typedef struct {
    bit        strobe_on;
    bit        overrun;
    bit        sample_valid;
    bit        sample_bank;
    bit [9:0]  sample_index;
    bit [15:0] sample_value;
    bit        revolution_done;
    bit [31:0] period_ticks;
    bit        finished_bank;
    bit [10:0] finished_count;
    bit [7:0]  revolution_count;
} t_tick_word;

class t_rotor_scoreboard;
    // registers
    bit        filt_on;
    bit [15:0] k_fb, k_in, k_prev;
    bit [10:0] spr;
    bit [23:0] flash_len;
    bit [31:0] init_intv;
    // block state
    bit [31:0] ticks, intv, smatch;
    bit        armed;
    bit [31:0] flash_at, dark_at;
    bit        lamp;
    bit        bank;
    bit [10:0] widx;
    bit [15:0] last_filt, last_raw;
    bit [7:0]  revs;
    bit        ovr;
    t_tick_word pending[$];
    int errors;

    function new();
        filt_on = RST_FILTER_ENABLE;
        k_fb = RST_COEF_FEEDBACK;
        k_in = RST_COEF_INPUT;
        k_prev = RST_COEF_PREV_INPUT;
        spr = RST_SAMPLES_PER_REV;
        flash_len = RST_FLASH_TICKS;
        init_intv = RST_INITIAL_INTERVAL;
        ticks = 0;
        intv = init_intv;
        smatch = init_intv;
        armed = 1;
        flash_at = ALL_ONES;
        dark_at = ALL_ONES;
        lamp = 0;
        bank = 0;
        widx = 0;
        last_filt = 0;
        last_raw = 0;
        revs = 0;
        ovr = 0;
        errors = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, bit [31:0] d);
        case (idx)
            CFG_FILTER_ENABLE:    filt_on = d[0];
            CFG_COEF_FEEDBACK:    k_fb = d[15:0];
            CFG_COEF_INPUT:       k_in = d[15:0];
            CFG_COEF_PREV_INPUT:  k_prev = d[15:0];
            CFG_SAMPLES_PER_REV:  spr = d[10:0];
            CFG_FLASH_TICKS:      flash_len = d[23:0];
            CFG_INITIAL_INTERVAL: begin
                init_intv = d;
                intv = (d == 0) ? 32'd1 : d;
                smatch = intv;
                armed = 1;
            end
            default: ;
        endcase
    endfunction

    function void light();
        lamp = 1;
        dark_at = ticks + ((flash_len == 0) ? 32'd1 : {8'd0, flash_len});
    endfunction

    function void note_tick(bit tach, bit [15:0] adc);
        t_tick_word w;
        bit [31:0] period, q;
        longint unsigned acc, nxt;
        w = '{default: 0};
        if (tach) begin
            period = ticks;
            ticks = 0;
            q = period / ((spr == 0) ? 32'd1 : {21'd0, spr});
            intv = (q == 0) ? 32'd1 : q;
            w.revolution_done = 1;
            w.period_ticks = period;
            w.finished_bank = bank;
            w.finished_count = widx;
            bank = ~bank;
            widx = 0;
            flash_at = period >> 1;
            smatch = intv;
            armed = 1;
            light();
            revs++;
        end else begin
            ticks++;
            if (ticks == dark_at) lamp = 0;
            if (ticks == flash_at) light();
            if (armed && ticks == smatch) begin
                if (widx >= 11'd1024) begin
                    ovr = 1;
                end else begin
                    ovr = 0;
                    w.sample_valid = 1;
                    w.sample_bank = bank;
                    w.sample_index = widx[9:0];
                    if (filt_on) begin
                        acc = longint'(k_fb) * last_filt + longint'(k_in) * adc
                            + longint'(k_prev) * last_raw;
                        acc = acc >> 16;
                        if (acc > 64'hFFFF) acc = 64'hFFFF;
                        last_filt = acc[15:0];
                        last_raw = adc;
                        w.sample_value = acc[15:0];
                    end else begin
                        w.sample_value = adc;
                    end
                    widx++;
                end
                nxt = longint'(smatch) + intv;
                if (nxt < 64'hFFFF_FFFF) smatch = nxt[31:0];
                else armed = 0;
            end
        end
        w.strobe_on = lamp;
        w.overrun = ovr;
        w.revolution_count = revs;
        pending.push_back(w);
    endfunction

    function void cmp(string name, bit [31:0] e, bit [31:0] a);
        if (e != a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endfunction

    function void check_word(t_tick_word got);
        t_tick_word e;
        if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        cmp("strobe_on", 32'(e.strobe_on), 32'(got.strobe_on));
        cmp("overrun", 32'(e.overrun), 32'(got.overrun));
        cmp("sample_valid", 32'(e.sample_valid), 32'(got.sample_valid));
        cmp("sample_bank", 32'(e.sample_bank), 32'(got.sample_bank));
        cmp("sample_index", 32'(e.sample_index), 32'(got.sample_index));
        cmp("sample_value", 32'(e.sample_value), 32'(got.sample_value));
        cmp("revolution_done", 32'(e.revolution_done), 32'(got.revolution_done));
        cmp("period_ticks", e.period_ticks, got.period_ticks);
        cmp("finished_bank", 32'(e.finished_bank), 32'(got.finished_bank));
        cmp("finished_count", 32'(e.finished_count), 32'(got.finished_count));
        cmp("revolution_count", 32'(e.revolution_count), 32'(got.revolution_count));
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT = 5000;

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_tach_edge;
    logic [15:0] i_adc_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_strobe_on, o_overrun, o_sample_valid, o_sample_bank;
    logic [9:0]  o_sample_index;
    logic [15:0] o_sample_value;
    logic        o_revolution_done;
    logic [31:0] o_period_ticks;
    logic        o_finished_bank;
    logic [10:0] o_finished_count;
    logic [7:0]  o_revolution_count;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_rotor_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_ctr = 0;
    int stall_mode = 0;
    int burst_left = 0;
    bit gapless = 0;

    rotor_synchronous_sampler_strobe_unit uut (.*);

    always #6 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        t_tick_word got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.strobe_on = o_strobe_on;
            got.overrun = o_overrun;
            got.sample_valid = o_sample_valid;
            got.sample_bank = o_sample_bank;
            got.sample_index = o_sample_index;
            got.sample_value = o_sample_value;
            got.revolution_done = o_revolution_done;
            got.period_ticks = o_period_ticks;
            got.finished_bank = o_finished_bank;
            got.finished_count = o_finished_count;
            got.revolution_count = o_revolution_count;
            sb.check_word(got);
        end
    end

    // receiver stall pattern, mode changes now and then
    always @(posedge i_clk) begin
        stall_ctr++;
        if (stall_ctr % 300 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= (stall_ctr % 7 < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_tick(bit tach, bit [15:0] adc);
        int gap;
        if (!gapless && burst_left == 0) begin
            if (i_in_valid) i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_tach_edge <= tach;
        i_adc_value <= adc;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_tick(tach, adc);
    endtask

    task automatic drain();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, bit [31:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(bit fe, bit [15:0] fb, bit [15:0] ci, bit [15:0] cp,
                           bit [10:0] spr, bit [23:0] fl, bit [31:0] init);
        write_cfg(CFG_FILTER_ENABLE, {31'd0, fe});
        write_cfg(CFG_COEF_FEEDBACK, {16'd0, fb});
        write_cfg(CFG_COEF_INPUT, {16'd0, ci});
        write_cfg(CFG_COEF_PREV_INPUT, {16'd0, cp});
        write_cfg(CFG_SAMPLES_PER_REV, {21'd0, spr});
        write_cfg(CFG_FLASH_TICKS, {8'd0, fl});
        write_cfg(CFG_INITIAL_INTERVAL, init);
    endtask

    // revolutions of random length, with a few stray edges as noise
    task automatic run_revs(int n, int min_len, int max_len);
        int since, span;
        bit tach;
        since = 0;
        span = $urandom_range(min_len, max_len);
        for (int i = 0; i < n; i++) begin
            tach = (since >= span) || ($urandom_range(0, 99) == 0);
            if (tach) begin
                since = 0;
                span = $urandom_range(min_len, max_len);
            end else begin
                since++;
            end
            send_tick(tach, 16'($urandom));
        end
    endtask

    initial begin
        bit [23:0] fl;
        bit [31:0] iv;
        bit [10:0] spr;
        i_rst_n = 0;
        i_in_valid = 0;
        i_tach_edge = 0;
        i_adc_value = 0;
        i_out_stall = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edge at count zero, back-to-back edges, saturation, raw mode
        send_tick(1, 16'hFFFF);
        send_tick(1, 16'h0000);
        send_tick(0, 16'h0000);
        drain();
        set_all(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd0, 24'd0, 32'd0);
        for (int i = 0; i < 8; i++) send_tick(0, (i % 2) ? 16'h0000 : 16'hFFFF);
        send_tick(1, 16'hFFFF);
        send_tick(1, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_tick(0, 16'hA5A5);
        drain();
        set_all(0, 16'd0, 16'd0, 16'd0, 11'd1024, 24'hFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++) send_tick(0, 16'h5A5A);
        send_tick(1, 16'h1234);
        send_tick(0, 16'hFFFF);
        drain();

        // full bank: one sample every tick for more than a bank
        set_all(0, 16'd0, 16'd0, 16'd0, 11'd1, 24'd3, 32'd1);
        gapless = 1;
        for (int i = 0; i < 1030; i++) send_tick(0, 16'($urandom));
        send_tick(1, 16'($urandom));
        for (int i = 0; i < 5; i++) send_tick(0, 16'($urandom));
        gapless = 0;
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            spr = (ph == 0) ? 11'd1024 : (ph == 1) ? 11'd0 : 11'($urandom_range(1, 16));
            fl = (ph == 2) ? 24'hFF_FFFF : (ph == 3) ? 24'd0 : 24'($urandom_range(1, 40));
            iv = (ph == 4) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 8));
            gapless = (ph % 3 == 0);
            set_all(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                    16'($urandom), spr, fl, iv);
            run_revs(120, 0, 120);
            drain();
        end
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
